>>> src/lpfp_pkg.sv
`timescale 1ns / 1ps

package lpfp_pkg;

    localparam int DEF_NUM_DEVICES = 4;
    localparam int WORDS_PER_DEV   = 8;
    localparam int DC_WORDS_PER_DEV = 4;

    localparam logic [11:0] LEVEL_MAX = 12'hFFF;
    localparam logic [5:0]  DOT_RESET = 6'd28;

    typedef enum logic [2:0] {
        CMD_WR12  = 3'd0,
        CMD_WR8   = 3'd1,
        CMD_FLUSH = 3'd2,
        CMD_TEST  = 3'd3,
        CMD_DOT   = 3'd4
    } cmd_t;

    typedef enum logic [1:0] {
        FK_GRAY,
        FK_TEST,
        FK_DOT
    } fkind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WR_RD,
        ST_WR_WB,
        ST_FR_RD,
        ST_FR_LOAD
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic load_cmd;
        logic wr_read;
        logic wr_write;
        logic fr_start;
        logic fr_read;
        logic fr_load;
    } lpfp_ctl_t;

    // datapath -> controller
    typedef struct packed {
        logic out_free;
        logic idx_last;
    } lpfp_sts_t;

endpackage

>>> src/lpfp_ctrl.sv
`timescale 1ns / 1ps

module lpfp_ctrl import lpfp_pkg::*; #(
    parameter int NUM_DEVICES = DEF_NUM_DEVICES
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_tvalid,
    output logic      s_tready,
    input  logic [2:0] s_cmd,
    input  logic [2:0] s_device,
    input  lpfp_sts_t sts,
    output lpfp_ctl_t ctl
);

    state_t state_reg;
    state_t state_next;
    logic   dev_ok;

    assign dev_ok = (4'(s_device) < 4'(NUM_DEVICES));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    case (cmd_t'(s_cmd))
                        CMD_WR12, CMD_WR8: begin
                            if (dev_ok) begin
                                state_next = ST_WR_RD;
                            end
                        end
                        CMD_FLUSH, CMD_TEST, CMD_DOT: state_next = ST_FR_RD;
                        default: state_next = ST_IDLE;
                    endcase
                end
            end
            ST_WR_RD:   state_next = ST_WR_WB;
            ST_WR_WB:   state_next = ST_IDLE;
            ST_FR_RD:   state_next = ST_FR_LOAD;
            ST_FR_LOAD: begin
                if (sts.out_free) begin
                    state_next = sts.idx_last ? ST_IDLE : ST_FR_RD;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        ctl      = '0;
        s_tready = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    case (cmd_t'(s_cmd))
                        CMD_WR12, CMD_WR8: ctl.load_cmd = dev_ok;
                        CMD_FLUSH, CMD_TEST, CMD_DOT: ctl.fr_start = 1'b1;
                        default: ctl = '0;
                    endcase
                end
            end
            ST_WR_RD:   ctl.wr_read  = 1'b1;
            ST_WR_WB:   ctl.wr_write = 1'b1;
            ST_FR_RD:   ctl.fr_read  = 1'b1;
            ST_FR_LOAD: ctl.fr_load  = sts.out_free;
            default:    ctl = '0;
        endcase
    end

endmodule

>>> src/lpfp_datapath.sv
`timescale 1ns / 1ps

module lpfp_datapath import lpfp_pkg::*; #(
    parameter int NUM_DEVICES = DEF_NUM_DEVICES
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic [2:0]  s_cmd,
    input  logic [2:0]  s_device,
    input  logic [3:0]  s_channel,
    input  logic [15:0] s_level,
    input  logic        cfg_wr_en,
    input  logic [5:0]  cfg_wr_data,
    input  lpfp_ctl_t   ctl,
    output lpfp_sts_t   sts,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_word,
    output logic        m_kind,
    output logic        m_last
);

    localparam int STORE_WORDS = WORDS_PER_DEV * NUM_DEVICES;
    localparam int DC_WORDS    = DC_WORDS_PER_DEV * NUM_DEVICES;
    localparam int ADDR_W      = $clog2(STORE_WORDS);
    localparam logic [ADDR_W-1:0] STORE_LAST = ADDR_W'(STORE_WORDS - 1);
    localparam logic [ADDR_W-1:0] DC_LAST    = ADDR_W'(DC_WORDS - 1);

    logic [23:0]            mem [STORE_WORDS];
    logic [STORE_WORDS-1:0] valid_reg;

    logic [ADDR_W-1:0] addr_reg;
    logic              odd_reg;
    logic [11:0]       value_reg;
    fkind_t            kind_reg;
    logic [ADDR_W-1:0] idx_reg;
    logic [5:0]        dot_level_reg;
    logic [23:0]       rd_data_reg;
    logic              rd_hit_reg;
    logic              m_tvalid_reg;
    logic [23:0]       m_word_reg;
    logic              m_kind_reg;
    logic              m_last_reg;

    logic [11:0]       value_next;
    logic [5:0]        word_sel;
    logic [ADDR_W-1:0] rd_addr;
    logic [23:0]       rd_word;
    logic [23:0]       merged;
    logic [23:0]       out_word;
    logic              clear_store;

    // 12-bit writes saturate; 8-bit writes replicate the high nibble below
    always_comb begin
        if (cmd_t'(s_cmd) == CMD_WR8) begin
            value_next = {s_level[7:0], s_level[7:4]};
        end else if (s_level > 16'(LEVEL_MAX)) begin
            value_next = LEVEL_MAX;
        end else begin
            value_next = s_level[11:0];
        end
    end

    assign word_sel = {s_device, s_channel[3:1]};
    assign rd_addr  = ctl.wr_read ? addr_reg : idx_reg;
    assign rd_word  = rd_hit_reg ? rd_data_reg : 24'd0;
    assign merged   = rd_word | (odd_reg ? {12'd0, value_reg} : {value_reg, 12'd0});

    assign sts.out_free = !m_tvalid_reg || m_tready;
    assign sts.idx_last = (kind_reg == FK_DOT) ? (idx_reg == DC_LAST)
                                               : (idx_reg == STORE_LAST);
    assign clear_store  = ctl.fr_load && sts.idx_last && (kind_reg != FK_DOT);

    always_comb begin
        case (kind_reg)
            FK_GRAY: out_word = rd_word;
            FK_TEST: out_word = 24'hFFFFFF;
            FK_DOT:  out_word = {4{dot_level_reg}};
            default: out_word = 24'd0;
        endcase
    end

    // store array and registered read port
    always_ff @(posedge aclk) begin
        if (ctl.wr_write) begin
            mem[addr_reg] <= merged;
        end
        if (ctl.wr_read || ctl.fr_read) begin
            rd_data_reg <= mem[rd_addr];
            rd_hit_reg  <= valid_reg[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (clear_store) begin
            valid_reg <= '0;
        end else if (ctl.wr_write) begin
            valid_reg[addr_reg] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.load_cmd) begin
            addr_reg  <= word_sel[ADDR_W-1:0];
            odd_reg   <= s_channel[0];
            value_reg <= value_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kind_reg <= FK_GRAY;
            idx_reg  <= '0;
        end else if (ctl.fr_start) begin
            case (cmd_t'(s_cmd))
                CMD_TEST: kind_reg <= FK_TEST;
                CMD_DOT:  kind_reg <= FK_DOT;
                default:  kind_reg <= FK_GRAY;
            endcase
            idx_reg <= '0;
        end else if (ctl.fr_load) begin
            idx_reg <= idx_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dot_level_reg <= DOT_RESET;
        end else if (cfg_wr_en) begin
            dot_level_reg <= cfg_wr_data;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (ctl.fr_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.fr_load) begin
            m_word_reg <= out_word;
            m_kind_reg <= (kind_reg == FK_DOT);
            m_last_reg <= sts.idx_last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_word   = m_word_reg;
    assign m_kind   = m_kind_reg;
    assign m_last   = m_last_reg;

    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.fr_load |-> (!m_tvalid_reg || m_tready))
        else $error("output register overwritten while held");

    a_clear_done: assert property (@(posedge aclk) disable iff (!aresetn)
        clear_store |=> (valid_reg == '0))
        else $error("store not cleared after frame");

    a_rmw_order: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.wr_write |-> $past(ctl.wr_read))
        else $error("write-back without preceding read");

    a_frame_read: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.fr_read |=> !ctl.fr_read)
        else $error("frame read issued twice in a row");

endmodule

>>> src/led_pwm_frame_packer_unit.sv
`timescale 1ns / 1ps

// Grayscale frame buffer for a chain of NUM_DEVICES LED drivers, 16 channels of
// 12 bits each, packed two channels per 24-bit word (even channel in 23:12, odd
// in 11:0). Commands arrive on the s_ stream: level writes OR into the store and
// produce nothing on m_; flush emits all 8*NUM_DEVICES words in order and clears
// the store; the test frame emits as many all-ones words and clears the store; the
// dot-correction frame emits 4*NUM_DEVICES words holding the dot level four times.
// A level write is a read-modify-write of the store (registered read, then
// write-back). A frame accepts the command, then per word does a registered
// store read and then an output load, the load waiting while m_tready holds
// the output register. A write to a device at or above NUM_DEVICES, or an
// unknown command, is accepted and dropped. The store is cleared through
// per-word valid bits, so no clear pass runs after reset. dot_level resets to 28.

module led_pwm_frame_packer_unit import lpfp_pkg::*; #(
    parameter int NUM_DEVICES = DEF_NUM_DEVICES
) (
    input  logic        aclk,
    input  logic        aresetn,
    // command stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // device [2:0], channel [6:3], level [22:7], zero [23]
    input  logic [2:0]  s_tuser,   // cmd [2:0]
    // frame word stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // packed_word [23:0]
    output logic        m_tuser,   // frame_kind [0]
    output logic        m_tlast,
    // dot_level register
    input  logic        cfg_wr_en,
    input  logic [5:0]  cfg_wr_data
);

    lpfp_ctl_t ctl;
    lpfp_sts_t sts;

    lpfp_ctrl #(
        .NUM_DEVICES(NUM_DEVICES)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_cmd    (s_tuser),
        .s_device (s_tdata[2:0]),
        .sts      (sts),
        .ctl      (ctl)
    );

    lpfp_datapath #(
        .NUM_DEVICES(NUM_DEVICES)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_cmd       (s_tuser),
        .s_device    (s_tdata[2:0]),
        .s_channel   (s_tdata[6:3]),
        .s_level     (s_tdata[22:7]),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .ctl         (ctl),
        .sts         (sts),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_word      (m_tdata),
        .m_kind      (m_tuser),
        .m_last      (m_tlast)
    );

endmodule
